/* rtl/gfc_pkg.sv */
// gfc_pkg: shared types, constants and helpers for the gated frequency counter
// used by every module under rtl; no dependencies of its own
`default_nettype none

package gfc_pkg;

  localparam int DATA_W       = 32;
  localparam int STEP_W       = 5;
  localparam int CNT_BITS_DEF = 32;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK = 2'd2;

  localparam logic [DATA_W-1:0] TPS_RST   = 32'd1000000000;
  localparam logic [DATA_W-1:0] GATE_RST  = 32'd1000000000;
  localparam logic [DATA_W-1:0] BLINK_RST = 32'd100000000;

  typedef enum logic [1:0] {
    ALU_HOLD = 2'd0,
    ALU_LOAD = 2'd1,
    ALU_MUL  = 2'd2,
    ALU_DIV  = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] lo_init;
  } alu_ctrl_t;

  typedef struct packed {
    logic              led;
    logic [DATA_W-1:0] freq;
    logic              done;
  } result_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_SAT   = 8'b0000_0100,
    ST_DIVF  = 8'b0000_1000,
    ST_FREQ  = 8'b0001_0000,
    ST_DIVP  = 8'b0010_0000,
    ST_PULSE = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  function automatic logic [DATA_W-1:0] at_least_one(input logic [DATA_W-1:0] v);
    at_least_one = (v == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/gfc_alu.sv */
// gfc_alu: shared shift/add unit, shift-add multiply and restoring divide
// one bit per cycle; depends on gfc_pkg
`default_nettype none

module gfc_alu
  import gfc_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF,
  localparam int HW = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W
) (
  input  wire logic                  clk,
  input  wire alu_ctrl_t             ctrl,
  input  wire logic [COUNT_BITS-1:0] cnt_in,
  output logic      [HW-1:0]         hi_o,
  output logic      [DATA_W-1:0]     lo_o
);

  localparam int AW = HW + 2;

  logic [COUNT_BITS-1:0] cnt_r;
  logic [HW-1:0]         hi_r, hi_nxt;
  logic [DATA_W-1:0]     lo_r, lo_nxt;
  logic [DATA_W:0]       div_a;
  logic [AW-1:0]         op_a, op_b, sum;
  logic                  sub, ge;

  always_comb begin
    div_a = {hi_r[DATA_W-1:0], lo_r[DATA_W-1]};
    sub   = (ctrl.op == ALU_DIV);
    if (sub) begin
      op_a = AW'(div_a);
      op_b = AW'(ctrl.divisor);
    end else begin
      op_a = AW'(hi_r);
      op_b = lo_r[0] ? AW'(cnt_r) : '0;
    end
    sum = op_a + (op_b ^ {AW{sub}}) + AW'(sub);
    ge  = ~sum[AW-1];
  end

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    case (ctrl.op)
      ALU_LOAD: begin
        hi_nxt = '0;
        lo_nxt = ctrl.lo_init;
      end
      ALU_MUL: begin
        hi_nxt = sum[HW:1];
        lo_nxt = {sum[0], lo_r[DATA_W-1:1]};
      end
      ALU_DIV: begin
        hi_nxt = ge ? HW'(sum[DATA_W-1:0]) : HW'(div_a[DATA_W-1:0]);
        lo_nxt = {lo_r[DATA_W-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (ctrl.op == ALU_LOAD) begin
      cnt_r <= cnt_in;
    end
  end

  assign hi_o = hi_r;
  assign lo_o = lo_r;

endmodule

`default_nettype wire

/* rtl/gfc_ctrl.sv */
// gfc_ctrl: tick sequencer, gate counter, pulse and one-shot timers
// drives gfc_alu for the frequency and period maths; depends on gfc_pkg
`default_nettype none

module gfc_ctrl
  import gfc_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF,
  localparam int HW = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  gate_event,
  input  wire logic                  signal_event,
  output logic                       busy,
  input  wire logic [DATA_W-1:0]     tps,
  input  wire logic [DATA_W-1:0]     gate_ticks,
  input  wire logic [DATA_W-1:0]     blink_ticks,
  output alu_ctrl_t                  alu_ctrl,
  output logic      [COUNT_BITS-1:0] alu_cnt,
  input  wire logic [HW-1:0]         alu_hi,
  input  wire logic [DATA_W-1:0]     alu_lo,
  output logic                       res_valid,
  output result_t                    res,
  input  wire logic                  out_free
);

  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  cp_r, cp_nxt;
  logic [COUNT_BITS-1:0] ec_r, ec_nxt;
  logic [DATA_W-1:0]     gr_r, gr_nxt;
  logic [DATA_W-1:0]     freq_r, freq_nxt;
  logic [DATA_W-1:0]     pr_r, pr_nxt;
  logic                  pa_r, pa_nxt;
  logic [DATA_W-1:0]     or_r, or_nxt;
  logic                  oa_r, oa_nxt;
  logic                  lvl_r, lvl_nxt;
  logic                  done_r, done_nxt;

  logic [DATA_W-1:0] gt1, period, half, blink1, on_time;
  logic              step_last, pf, done, cp_t;

  always_comb begin
    gt1       = at_least_one(gate_ticks);
    blink1    = at_least_one(blink_ticks);
    period    = at_least_one(alu_lo);
    half      = period >> 1;
    on_time   = at_least_one((half < blink1) ? half : blink1);
    step_last = &step_r;

    state_nxt = state_r;
    step_nxt  = step_r;
    cp_nxt    = cp_r;
    ec_nxt    = ec_r;
    gr_nxt    = gr_r;
    freq_nxt  = freq_r;
    pr_nxt    = pr_r;
    pa_nxt    = pa_r;
    or_nxt    = or_r;
    oa_nxt    = oa_r;
    lvl_nxt   = lvl_r;
    done_nxt  = done_r;
    pf        = 1'b0;
    done      = 1'b0;
    cp_t      = cp_r;

    alu_ctrl.op      = ALU_HOLD;
    alu_ctrl.divisor = gt1;
    alu_ctrl.lo_init = tps;

    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          if (pa_r) begin
            pr_nxt = pr_r - 1'b1;
            if (pr_r == 32'd1) begin
              pa_nxt = 1'b0;
              pf     = 1'b1;
            end
          end
          if (oa_r) begin
            or_nxt = or_r - 1'b1;
            if (or_r == 32'd1) begin
              oa_nxt  = 1'b0;
              lvl_nxt = 1'b0;
            end
          end
          if (cp_r) begin
            gr_nxt = gr_r - 1'b1;
            if (gr_r == 32'd1) begin
              cp_t = 1'b0;
              done = 1'b1;
            end else if (signal_event && !(&ec_r)) begin
              ec_nxt = ec_r + 1'b1;
            end
          end
          if (!cp_t && gate_event) begin
            ec_nxt = COUNT_BITS'(signal_event);
            gr_nxt = gt1;
            cp_t   = 1'b1;
          end
          cp_nxt      = cp_t;
          done_nxt    = done;
          alu_ctrl.op = ALU_LOAD;
          if (done) begin
            state_nxt = ST_MUL;
          end else if (pf && (freq_r != '0)) begin
            state_nxt = ST_DIVP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        alu_ctrl.op = ALU_MUL;
        step_nxt    = step_r + 1'b1;
        if (step_last) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        step_nxt = '0;
        if (alu_hi >= HW'(gt1)) begin
          freq_nxt    = '1;
          alu_ctrl.op = ALU_LOAD;
          state_nxt   = ST_DIVP;
        end else begin
          state_nxt = ST_DIVF;
        end
      end
      ST_DIVF: begin
        alu_ctrl.op = ALU_DIV;
        step_nxt    = step_r + 1'b1;
        if (step_last) begin
          state_nxt = ST_FREQ;
        end
      end
      ST_FREQ: begin
        step_nxt = '0;
        freq_nxt = alu_lo;
        if (alu_lo != '0) begin
          alu_ctrl.op = ALU_LOAD;
          state_nxt   = ST_DIVP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_DIVP: begin
        alu_ctrl.op      = ALU_DIV;
        alu_ctrl.divisor = freq_r;
        step_nxt         = step_r + 1'b1;
        if (step_last) begin
          state_nxt = ST_PULSE;
        end
      end
      ST_PULSE: begin
        lvl_nxt   = 1'b1;
        pr_nxt    = period;
        pa_nxt    = 1'b1;
        or_nxt    = on_time;
        oa_nxt    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cp_r    <= 1'b0;
      ec_r    <= '0;
      gr_r    <= '0;
      freq_r  <= '0;
      pr_r    <= '0;
      pa_r    <= 1'b0;
      or_r    <= '0;
      oa_r    <= 1'b0;
      lvl_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cp_r    <= cp_nxt;
      ec_r    <= ec_nxt;
      gr_r    <= gr_nxt;
      freq_r  <= freq_nxt;
      pr_r    <= pr_nxt;
      pa_r    <= pa_nxt;
      or_r    <= or_nxt;
      oa_r    <= oa_nxt;
      lvl_r   <= lvl_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign alu_cnt   = ec_r;
  assign res_valid = (state_r == ST_FIN);
  assign res.led   = lvl_r;
  assign res.freq  = freq_r;
  assign res.done  = done_r;

endmodule

`default_nettype wire

/* rtl/gated_frequency_counter_pulse_mimic.sv */
// one tick per word; a plain tick goes straight to FIN, a tick that fires the
// pulse period also runs a divide, and one that closes the gate window runs a
// shift-add multiply and up to two divides on the one shared shift/add unit
// one tick in flight at a time; the result register frees the input side early
// rst_n is synchronous: state cleared, config registers back to defaults
// top level: config registers, result register, gfc_ctrl and gfc_alu; uses gfc_pkg
`default_nettype none

module gated_frequency_counter_pulse_mimic
  import gfc_pkg::*;
#(
  parameter int COUNT_BITS = CNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_gate_event,
  input  wire logic                 in_signal_event,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_led_level,
  output logic     [DATA_W-1:0]     out_frequency,
  output logic                      out_measurement_done,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wdata
);

  localparam int HW = (COUNT_BITS > DATA_W) ? COUNT_BITS : DATA_W;

  logic [DATA_W-1:0]     tps_r, gate_r, blink_r;
  logic                  out_valid_r;
  result_t               out_r;
  logic                  busy, res_valid, out_free;
  result_t               res;
  alu_ctrl_t             alu_ctrl;
  logic [COUNT_BITS-1:0] alu_cnt;
  logic [HW-1:0]         alu_hi;
  logic [DATA_W-1:0]     alu_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r   <= TPS_RST;
      gate_r  <= GATE_RST;
      blink_r <= BLINK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TPS:   tps_r   <= cfg_wdata;
        REG_GATE:  gate_r  <= cfg_wdata;
        REG_BLINK: blink_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_r <= res;
    end
  end

  gfc_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .gate_event  (in_gate_event),
    .signal_event(in_signal_event),
    .busy        (busy),
    .tps         (tps_r),
    .gate_ticks  (gate_r),
    .blink_ticks (blink_r),
    .alu_ctrl    (alu_ctrl),
    .alu_cnt     (alu_cnt),
    .alu_hi      (alu_hi),
    .alu_lo      (alu_lo),
    .res_valid   (res_valid),
    .res         (res),
    .out_free    (out_free)
  );

  gfc_alu #(
    .COUNT_BITS(COUNT_BITS)
  ) u_alu (
    .clk   (clk),
    .ctrl  (alu_ctrl),
    .cnt_in(alu_cnt),
    .hi_o  (alu_hi),
    .lo_o  (alu_lo)
  );

  assign in_stall             = busy;
  assign out_valid            = out_valid_r;
  assign out_led_level        = out_r.led;
  assign out_frequency        = out_r.freq;
  assign out_measurement_done = out_r.done;

endmodule

`default_nettype wire

/* rtl/gfc_chk.sv */
// gfc_chk: port-level checks for the gated frequency counter, bound to the top
// depends on gfc_pkg
`default_nettype none

module gfc_chk
  import gfc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_led_level,
  input wire logic [DATA_W-1:0] out_frequency,
  input wire logic              out_measurement_done
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new word taken while previous tick still in work");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frequency)
      && $stable(out_led_level) && $stable(out_measurement_done))
    else $error("stalled result word changed");

endmodule

bind gated_frequency_counter_pulse_mimic gfc_chk u_gfc_chk (.*);

`default_nettype wire
